FILE: src/mswp_pkg.sv
// ----------------------------------------------------------------------------
// mswp_pkg: shared types and constants for the pivot window score block
// Holds the sequencer state type and the fixed widths of the config and
// result fields.
// ----------------------------------------------------------------------------
package mswp_pkg;

  // Fixed field widths
  localparam int PIVOT_W = 10;
  localparam int SCORE_W = 26;
  localparam int OUT_DW  = 32;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_LOAD,
    ST_RD_PIV,
    ST_PIV,
    ST_LEFT,
    ST_MUL,
    ST_STEP,
    ST_OUT
  } mswp_state_e;

endpackage

FILE: src/mswp_ram.sv
// ----------------------------------------------------------------------------
// mswp_ram: generic simple dual-port RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module mswp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: src/max_score_window_around_pivot.sv
// ----------------------------------------------------------------------------
// max_score_window_around_pivot: best window score grown from a pivot
// Loads one word per cycle, then grows a window outward from the pivot and
// emits the best window minimum times window length.
// ----------------------------------------------------------------------------
// The block is ready in every load cycle.
// After the last word of a set of N words come three setup reads, then for
// each of the N windows scored a RAM read plus multiply, then a compare;
// input stalls until the result is taken.
// A pivot outside the set gives an error result on the next cycle.
// Reset clears the sequencer, word counter and pivot, but not the value store.
module max_score_window_around_pivot #(
  parameter int MAX_LEN    = 1024,
  parameter int VALUE_BITS = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // Config: pivot index
  input  logic                                   cfg_we_i,
  input  logic [mswp_pkg::PIVOT_W-1:0]           cfg_wdata_i,
  // Input stream
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // tdata: value [VALUE_BITS-1:0], zero pad above
  input  logic [((VALUE_BITS+7)/8)*8-1:0]        s_axis_tdata,
  input  logic                                   s_axis_tlast,
  // Output stream
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // tdata: score [25:0], zero pad [31:26]
  output logic [mswp_pkg::OUT_DW-1:0]            m_axis_tdata,
  // tuser: error [0]
  output logic                                   m_axis_tuser
);

  import mswp_pkg::*;

  localparam int IW    = $clog2(MAX_LEN);
  localparam int LW    = IW + 1;
  localparam int PW    = VALUE_BITS + LW;
  localparam int CMPW  = (LW > PIVOT_W) ? LW : PIVOT_W;
  localparam int EXT_W = PW + SCORE_W;

  mswp_state_e state_q, state_d;

  logic [PIVOT_W-1:0]    pivot_q;
  logic [LW-1:0]         cnt_q, cnt_d;
  logic [IW-1:0]         lo_q, lo_d, hi_q, hi_d;
  logic [VALUE_BITS-1:0] mn_q, mn_d, lv_q, lv_d, rv_q, rv_d;
  logic [PW-1:0]         prod_q, prod_d, best_q, best_d;
  logic                  left_q, left_d;
  logic [SCORE_W-1:0]    score_q, score_d;
  logic                  err_q, err_d;

  logic                  in_acc, out_acc;
  logic                  ram_we;
  logic [IW-1:0]         raddr;
  logic [VALUE_BITS-1:0] rdata;
  logic [CMPW-1:0]       pivot_ext;
  logic [IW-1:0]         pivot_idx;
  logic                  has_l, has_r, go_left;
  logic [LW-1:0]         win_len;
  logic [PW-1:0]         best_nx;
  logic [EXT_W-1:0]      best_ext;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;
  assign ram_we  = in_acc && (cnt_q < LW'(MAX_LEN));

  assign pivot_ext = CMPW'(pivot_q);
  assign pivot_idx = pivot_ext[IW-1:0];

  // Neighbor availability and growth direction, left on a tie
  assign has_l   = (lo_q != '0);
  assign has_r   = ((LW'(hi_q) + LW'(1)) < cnt_q);
  assign go_left = has_l && (!has_r || (lv_q >= rv_q));

  assign win_len  = LW'(hi_q) - LW'(lo_q) + LW'(1);
  assign best_nx  = (prod_q > best_q) ? prod_q : best_q;
  assign best_ext = EXT_W'(best_nx);

  // Value store
  mswp_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (MAX_LEN)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cnt_q[IW-1:0]),
    .wdata_i (s_axis_tdata[VALUE_BITS-1:0]),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Hold the pivot register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pivot_q <= '0;
    end else if (cfg_we_i) begin
      pivot_q <= cfg_wdata_i;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    mn_q    <= mn_d;
    lv_q    <= lv_d;
    rv_q    <= rv_d;
    prod_q  <= prod_d;
    best_q  <= best_d;
    left_q  <= left_d;
    score_q <= score_d;
    err_q   <= err_d;
  end

  // Sequencer: next state, datapath updates and RAM read address
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    lo_d    = lo_q;
    hi_d    = hi_q;
    mn_d    = mn_q;
    lv_d    = lv_q;
    rv_d    = rv_q;
    prod_d  = prod_q;
    best_d  = best_q;
    left_d  = left_q;
    score_d = score_q;
    err_d   = err_q;
    raddr   = '0;

    case (state_q)
      ST_LOAD: begin
        if (in_acc) begin
          if (ram_we) begin
            cnt_d = cnt_q + LW'(1);
          end
          if (s_axis_tlast) begin
            if (pivot_ext >= CMPW'(cnt_d)) begin
              score_d = '0;
              err_d   = 1'b1;
              state_d = ST_OUT;
            end else begin
              lo_d    = pivot_idx;
              hi_d    = pivot_idx;
              state_d = ST_RD_PIV;
            end
          end
        end
      end
      ST_RD_PIV: begin
        raddr   = pivot_idx;
        state_d = ST_PIV;
      end
      ST_PIV: begin
        mn_d    = rdata;
        best_d  = '0;
        raddr   = lo_q - IW'(1);
        state_d = ST_LEFT;
      end
      ST_LEFT: begin
        lv_d    = rdata;
        left_d  = 1'b0;
        raddr   = hi_q + IW'(1);
        state_d = ST_MUL;
      end
      ST_MUL: begin
        // Refill the neighbor on the side just taken, then score the window
        if (left_q) begin
          lv_d = rdata;
        end else begin
          rv_d = rdata;
        end
        prod_d  = PW'(mn_q) * PW'(win_len);
        state_d = ST_STEP;
      end
      ST_STEP: begin
        best_d = best_nx;
        if (!has_l && !has_r) begin
          score_d = best_ext[SCORE_W-1:0];
          err_d   = 1'b0;
          state_d = ST_OUT;
        end else begin
          left_d = go_left;
          if (go_left) begin
            lo_d  = lo_q - IW'(1);
            mn_d  = (lv_q < mn_q) ? lv_q : mn_q;
            raddr = (lo_q - IW'(1)) - IW'(1);
          end else begin
            hi_d  = hi_q + IW'(1);
            mn_d  = (rv_q < mn_q) ? rv_q : mn_q;
            raddr = (hi_q + IW'(1)) + IW'(1);
          end
          state_d = ST_MUL;
        end
      end
      ST_OUT: begin
        if (out_acc) begin
          cnt_d   = '0;
          state_d = ST_LOAD;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  // Stream outputs
  assign s_axis_tready = (state_q == ST_LOAD);
  assign m_axis_tvalid = (state_q == ST_OUT);
  assign m_axis_tdata  = OUT_DW'(score_q);
  assign m_axis_tuser  = err_q;

  // Assertions
  a_window_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_STEP) |-> (lo_q <= hi_q))
    else $error("window left edge beyond right edge");

  a_window_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_STEP) |-> (LW'(hi_q) < cnt_q))
    else $error("window right edge beyond loaded length");

  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (score_q == '0))
    else $error("error result carries a nonzero score");

  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !m_axis_tvalid)
    else $error("input accepted while a result is pending");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= LW'(MAX_LEN))
    else $error("word count beyond store depth");

endmodule
